### hw/rtl/generational_slot_allocator_macros.svh
// Assertion shorthands for the slot allocator checker.
`ifndef GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_SLOT_ALLOCATOR_MACROS_SVH

// plain property, sampled on clk, off during reset
`define GSA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// same-cycle implication
`define GSA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define GSA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/gsa_pkg.sv
package gsa_pkg;

	localparam int GEN_W = 32;

	localparam logic [1:0] OP_ACQUIRE = 2'd0;
	localparam logic [1:0] OP_RELEASE = 2'd1;
	localparam logic [1:0] OP_READ    = 2'd2;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_NONE_FREE    = 2'd1;
	localparam logic [1:0] ST_NOT_IN_USE   = 2'd2;
	localparam logic [1:0] ST_BAD_POSITION = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [5:0] slot;
		logic [5:0] position;
	} cmd_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [5:0]       slot_out;
		logic [GEN_W-1:0] generation;
		logic [6:0]       active_count;
	} result_t;

	function automatic result_t make_result(logic [1:0] st, logic [5:0] s,
			logic [GEN_W-1:0] g, logic [6:0] c);
		result_t r;
		r.status       = st;
		r.slot_out     = s;
		r.generation   = g;
		r.active_count = c;
		return r;
	endfunction

endpackage

### hw/rtl/gsa_ram.sv
module gsa_ram #(
	parameter int W = 8,
	parameter int D = 64
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];
	logic [W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hw/rtl/generational_slot_allocator.sv
// Generational slot allocator.
// Command channel: cmd is taken at a rising edge with start high and busy low.
// Opcodes: acquire pops the free stack, release returns a slot in use and bumps
// its generation, read returns the active list entry at cmd.position.
// Result channel: done is high for exactly one cycle with result valid; the
// receiver cannot stall, so each result is a transfer in that cycle.
// Path from the accepting edge to done: acquire passes decode, generation read and
// write; read passes decode, list read and output; no free slot, bad position and
// the unused opcode end in decode; release of a slot not in use ends in the check;
// release walks active list entries until the slot is found (at most the active count).
// The active list walk reads one entry per cycle through a single memory read
// port; busy stays high for the whole operation, and a new command can be
// accepted in the cycle done is shown.
// After reset busy stays high while the free stack is filled
// with SLOTS-1 down to 0 and the generation/in-use memory is cleared, one
// entry per cycle. Acquires after that hand out slots 0, 1, 2, ...
module generational_slot_allocator import gsa_pkg::*; #(
	parameter int SLOTS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	output logic    busy,
	input  cmd_t    cmd,
	output logic    done,
	output result_t result
);

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_INIT, S_IDLE, S_DECODE, S_ACQ_GEN, S_ACQ_WR,
		S_REL_CHK, S_REL_LAST, S_REL_SCAN, S_RD_GEN, S_RD_OUT
	} state_t;

	state_t           state_q;
	logic [IW-1:0]    init_q;
	cmd_t             cmd_q;
	logic [IW-1:0]    slot_q;
	logic [IW-1:0]    last_q;
	logic [IW-1:0]    scan_q;
	logic [CW-1:0]    free_q;
	logic [CW-1:0]    act_q;
	logic [GEN_W-1:0] gen_q;
	logic             done_q;
	result_t          result_q;

	logic             fs_we, gw_we, al_we;
	logic [IW-1:0]    fs_waddr, fs_raddr, gw_waddr, gw_raddr, al_waddr, al_raddr;
	logic [IW-1:0]    fs_wdata, fs_rdata, al_wdata, al_rdata;
	logic [GEN_W:0]   gw_wdata, gw_rdata;
	logic [GEN_W-1:0] gen_inc;

	assign gen_inc = gw_rdata[GEN_W-1:0] + GEN_W'(1);

	gsa_ram #(.W(IW), .D(SLOTS)) u_free_stack (
		.clk(clk), .we(fs_we), .waddr(fs_waddr), .wdata(fs_wdata),
		.raddr(fs_raddr), .rdata(fs_rdata)
	);

	// {in_use, generation} per slot
	gsa_ram #(.W(GEN_W + 1), .D(SLOTS)) u_gen_table (
		.clk(clk), .we(gw_we), .waddr(gw_waddr), .wdata(gw_wdata),
		.raddr(gw_raddr), .rdata(gw_rdata)
	);

	gsa_ram #(.W(IW), .D(SLOTS)) u_active_list (
		.clk(clk), .we(al_we), .waddr(al_waddr), .wdata(al_wdata),
		.raddr(al_raddr), .rdata(al_rdata)
	);

	always_comb begin
		fs_we    = 1'b0;
		fs_waddr = '0;
		fs_wdata = '0;
		fs_raddr = '0;
		gw_we    = 1'b0;
		gw_waddr = '0;
		gw_wdata = '0;
		gw_raddr = '0;
		al_we    = 1'b0;
		al_waddr = '0;
		al_wdata = '0;
		al_raddr = '0;
		case (state_q)
			S_INIT: begin
				fs_we    = 1'b1;
				fs_waddr = init_q;
				fs_wdata = IW'(SLOTS - 1) - init_q;
				gw_we    = 1'b1;
				gw_waddr = init_q;
			end
			S_DECODE: begin
				fs_raddr = IW'(free_q - CW'(1));
				gw_raddr = IW'(cmd_q.slot);
				al_raddr = IW'(cmd_q.position);
			end
			S_ACQ_GEN: begin
				gw_raddr = fs_rdata;
			end
			S_ACQ_WR: begin
				gw_we    = 1'b1;
				gw_waddr = slot_q;
				gw_wdata = {1'b1, gw_rdata[GEN_W-1:0]};
				al_we    = 1'b1;
				al_waddr = IW'(act_q);
				al_wdata = slot_q;
			end
			S_REL_CHK: begin
				if (gw_rdata[GEN_W]) begin
					gw_we    = 1'b1;
					gw_waddr = slot_q;
					gw_wdata = {1'b0, gen_inc};
					fs_we    = (32'(free_q) < SLOTS);
					fs_waddr = IW'(free_q);
					fs_wdata = slot_q;
				end
				al_raddr = IW'(act_q - CW'(1));
			end
			S_REL_LAST: begin
				al_raddr = '0;
			end
			S_REL_SCAN: begin
				al_raddr = scan_q + IW'(1);
				if (al_rdata == slot_q) begin
					al_we    = 1'b1;
					al_waddr = scan_q;
					al_wdata = last_q;
				end
			end
			S_RD_GEN: begin
				gw_raddr = al_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_INIT;
			init_q   <= '0;
			cmd_q    <= '0;
			slot_q   <= '0;
			last_q   <= '0;
			scan_q   <= '0;
			free_q   <= CW'(SLOTS);
			act_q    <= '0;
			gen_q    <= '0;
			done_q   <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_INIT: begin
					init_q <= init_q + IW'(1);
					if (init_q == IW'(SLOTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					case (cmd_q.opcode)
						OP_ACQUIRE: begin
							if (free_q == '0 || 32'(act_q) >= SLOTS) begin
								result_q <= make_result(ST_NONE_FREE, '0, '0, 7'(act_q));
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								free_q  <= free_q - CW'(1);
								state_q <= S_ACQ_GEN;
							end
						end
						OP_RELEASE: begin
							if (32'(cmd_q.slot) >= SLOTS) begin
								result_q <= make_result(ST_NOT_IN_USE, '0, '0, 7'(act_q));
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								slot_q  <= IW'(cmd_q.slot);
								state_q <= S_REL_CHK;
							end
						end
						OP_READ: begin
							if (32'(cmd_q.position) >= 32'(act_q)) begin
								result_q <= make_result(ST_BAD_POSITION, '0, '0, 7'(act_q));
								done_q   <= 1'b1;
								state_q  <= S_IDLE;
							end else begin
								state_q <= S_RD_GEN;
							end
						end
						default: begin
							result_q <= make_result(ST_OK, '0, '0, 7'(act_q));
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					endcase
				end
				S_ACQ_GEN: begin
					slot_q  <= fs_rdata;
					state_q <= S_ACQ_WR;
				end
				S_ACQ_WR: begin
					act_q    <= act_q + CW'(1);
					result_q <= make_result(ST_OK, 6'(slot_q), gw_rdata[GEN_W-1:0],
						7'(act_q + CW'(1)));
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				S_REL_CHK: begin
					if (!gw_rdata[GEN_W]) begin
						result_q <= make_result(ST_NOT_IN_USE, '0, '0, 7'(act_q));
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						gen_q <= gen_inc;
						if (32'(free_q) < SLOTS) begin
							free_q <= free_q + CW'(1);
						end
						if (act_q == '0) begin
							result_q <= make_result(ST_OK, 6'(slot_q), gen_inc, 7'(act_q));
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end else begin
							state_q <= S_REL_LAST;
						end
					end
				end
				S_REL_LAST: begin
					last_q  <= al_rdata;
					scan_q  <= '0;
					state_q <= S_REL_SCAN;
				end
				S_REL_SCAN: begin
					if (al_rdata == slot_q) begin
						act_q    <= act_q - CW'(1);
						result_q <= make_result(ST_OK, 6'(slot_q), gen_q,
							7'(act_q - CW'(1)));
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else if (32'(scan_q) + 32'd1 >= 32'(act_q)) begin
						result_q <= make_result(ST_OK, 6'(slot_q), gen_q, 7'(act_q));
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						scan_q <= scan_q + IW'(1);
					end
				end
				S_RD_GEN: begin
					slot_q  <= al_rdata;
					state_q <= S_RD_OUT;
				end
				S_RD_OUT: begin
					result_q <= make_result(ST_OK, 6'(slot_q), gw_rdata[GEN_W-1:0], 7'(act_q));
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign result = result_q;

endmodule

### hw/rtl/gsa_checker.sv
`include "generational_slot_allocator_macros.svh"

module gsa_checker import gsa_pkg::*; #(
	parameter int SLOTS = 64
) (
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	`GSA_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted command did not raise busy")
	`GSA_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
	`GSA_ASSERT_IMP(a_done_after_busy, done, $past(busy), "result without a command in flight")
	`GSA_ASSERT_IMP(a_err_zero, done && result.status != ST_OK, result.slot_out == '0 && result.generation == '0, "error result carries nonzero slot or generation")
	`GSA_ASSERT(a_count_range, !done || 32'(result.active_count) <= SLOTS, "active count above slot total")

endmodule

bind generational_slot_allocator gsa_checker #(.SLOTS(SLOTS)) u_gsa_checker (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.result(result)
);

### sim/tb_generational_slot_allocator.sv
module tb_generational_slot_allocator;
	import gsa_pkg::*;

	localparam int SLOTS = 64;
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 4000;
	localparam int TAIL_CYCLES = 80;

	typedef struct {
		cmd_t    c;
		bit      typed;
		result_t r;
	} row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	cmd_t    cmd = '0;
	logic    busy;
	logic    done;
	result_t result;

	// allocator shadow state
	logic [5:0]  free_slots [SLOTS];
	logic [6:0]  free_top;
	logic [31:0] gen_of [SLOTS];
	logic        in_use [SLOTS];
	logic [5:0]  live [SLOTS];
	logic [6:0]  live_total;

	result_t outcomes_due [$];
	result_t want;
	row_t    plan [$];
	int      errors = 0;
	int      stalled = 0;

	generational_slot_allocator #(.SLOTS(SLOTS)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	always #6 clk = ~clk;

	function automatic result_t slot_outcome(cmd_t c);
		result_t r;
		logic [5:0] s;
		int idx;
		r = '0;
		r.status = ST_OK;
		case (c.opcode)
			OP_ACQUIRE: begin
				if (free_top == 0 || live_total >= SLOTS) begin
					r.status = ST_NONE_FREE;
				end else begin
					free_top = free_top - 7'd1;
					s = free_slots[free_top];
					in_use[s] = 1'b1;
					live[live_total] = s;
					live_total = live_total + 7'd1;
					r.slot_out = s;
					r.generation = gen_of[s];
				end
			end
			OP_RELEASE: begin
				if (!in_use[c.slot]) begin
					r.status = ST_NOT_IN_USE;
				end else begin
					in_use[c.slot] = 1'b0;
					for (idx = 0; idx < live_total; idx++) begin
						if (live[idx] == c.slot) begin
							live[idx] = live[live_total - 7'd1];
							live_total = live_total - 7'd1;
							break;
						end
					end
					gen_of[c.slot] = gen_of[c.slot] + 32'd1;
					if (free_top < SLOTS) begin
						free_slots[free_top] = c.slot;
						free_top = free_top + 7'd1;
					end
					r.slot_out = c.slot;
					r.generation = gen_of[c.slot];
				end
			end
			OP_READ: begin
				if (c.position >= live_total) begin
					r.status = ST_BAD_POSITION;
				end else begin
					s = live[c.position];
					r.slot_out = s;
					r.generation = gen_of[s];
				end
			end
			default: ;
		endcase
		r.active_count = live_total;
		return r;
	endfunction

	function automatic row_t step_row(logic [1:0] op, logic [5:0] s, logic [5:0] p, bit typed,
			logic [1:0] st, logic [5:0] so, logic [31:0] g, logic [6:0] n);
		row_t w;
		w.c.opcode = op;
		w.c.slot = s;
		w.c.position = p;
		w.typed = typed;
		w.r.status = st;
		w.r.slot_out = so;
		w.r.generation = g;
		w.r.active_count = n;
		return w;
	endfunction

	// mostly well-formed: releases of slots in use, reads inside the active list
	function automatic cmd_t draw_cmd(int acq_pct, int rel_pct);
		cmd_t c;
		int p;
		c = cmd_t'($urandom);
		p = $urandom_range(0, 99);
		if (p < acq_pct) begin
			c.opcode = OP_ACQUIRE;
		end else if (p < acq_pct + rel_pct) begin
			c.opcode = OP_RELEASE;
			if (live_total != 0 && $urandom_range(0, 99) < 85)
				c.slot = live[$urandom_range(0, live_total - 1)];
		end else if (p < 97) begin
			c.opcode = OP_READ;
			if (live_total != 0 && $urandom_range(0, 99) < 85)
				c.position = 6'($urandom_range(0, live_total - 1));
		end else begin
			c.opcode = OP_UNUSED;
		end
		return c;
	endfunction

	task automatic issue(cmd_t c, bit typed, result_t typed_r);
		result_t r;
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		r = slot_outcome(c);
		outcomes_due.push_back(typed ? typed_r : r);
	endtask

	task automatic maybe_idle(int pct);
		if ($urandom_range(0, 99) < pct) begin
			start <= 1'b0;
			cmd <= cmd_t'($urandom);
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do @(posedge clk); while (outcomes_due.size() != 0);
	endtask

	task automatic run_phase(int n, int acq_pct, int rel_pct, int idle_pct);
		int k;
		for (k = 0; k < n; k++) begin
			issue(draw_cmd(acq_pct, rel_pct), 1'b0, '0);
			maybe_idle(idle_pct);
		end
		drain_results();
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (outcomes_due.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual %p", $time, result);
				errors++;
			end else begin
				want = outcomes_due.pop_front();
				if (result.status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, result.status);
					errors++;
				end
				if (result.slot_out !== want.slot_out) begin
					$display("%0t: slot_out expected %0d actual %0d",
						$time, want.slot_out, result.slot_out);
					errors++;
				end
				if (result.generation !== want.generation) begin
					$display("%0t: generation expected %0d actual %0d",
						$time, want.generation, result.generation);
					errors++;
				end
				if (result.active_count !== want.active_count) begin
					$display("%0t: active_count expected %0d actual %0d",
						$time, want.active_count, result.active_count);
					errors++;
				end
			end
		end
	end

	// watchdog: cycles with no transfer on either side
	always @(posedge clk) begin
		if (arst_n && ((start && !busy) || done))
			stalled <= 0;
		else
			stalled <= stalled + 1;
		if (stalled >= STALL_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		for (int k = 0; k < SLOTS; k++) begin
			free_slots[k] = 6'(SLOTS - 1 - k);
			gen_of[k] = '0;
			in_use[k] = 1'b0;
			live[k] = '0;
		end
		free_top = 7'(SLOTS);
		live_total = '0;

		plan.push_back(step_row(OP_READ,    6'd0,  6'd0,  1'b1, ST_BAD_POSITION, 6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_RELEASE, 6'd0,  6'd0,  1'b1, ST_NOT_IN_USE,   6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_RELEASE, 6'd63, 6'd0,  1'b1, ST_NOT_IN_USE,   6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_UNUSED,  6'd63, 6'd63, 1'b1, ST_OK,           6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_ACQUIRE, 6'd0,  6'd0,  1'b1, ST_OK,           6'd0, 0, 7'd1));
		plan.push_back(step_row(OP_ACQUIRE, 6'd63, 6'd63, 1'b1, ST_OK,           6'd1, 0, 7'd2));
		plan.push_back(step_row(OP_READ,    6'd0,  6'd0,  1'b1, ST_OK,           6'd0, 0, 7'd2));
		plan.push_back(step_row(OP_READ,    6'd0,  6'd1,  1'b1, ST_OK,           6'd1, 0, 7'd2));
		plan.push_back(step_row(OP_READ,    6'd0,  6'd2,  1'b1, ST_BAD_POSITION, 6'd0, 0, 7'd2));
		plan.push_back(step_row(OP_READ,    6'd63, 6'd63, 1'b1, ST_BAD_POSITION, 6'd0, 0, 7'd2));
		// release of the first entry: last entry moves into its place
		plan.push_back(step_row(OP_RELEASE, 6'd0,  6'd0,  1'b1, ST_OK,           6'd0, 1, 7'd1));
		plan.push_back(step_row(OP_READ,    6'd0,  6'd0,  1'b1, ST_OK,           6'd1, 0, 7'd1));
		plan.push_back(step_row(OP_ACQUIRE, 6'd0,  6'd0,  1'b1, ST_OK,           6'd0, 1, 7'd2));
		plan.push_back(step_row(OP_READ,    6'd0,  6'd1,  1'b1, ST_OK,           6'd0, 1, 7'd2));
		plan.push_back(step_row(OP_RELEASE, 6'd1,  6'd0,  1'b1, ST_OK,           6'd1, 1, 7'd1));
		plan.push_back(step_row(OP_RELEASE, 6'd1,  6'd0,  1'b1, ST_NOT_IN_USE,   6'd0, 0, 7'd1));
		plan.push_back(step_row(OP_RELEASE, 6'd63, 6'd63, 1'b1, ST_NOT_IN_USE,   6'd0, 0, 7'd1));
		plan.push_back(step_row(OP_UNUSED,  6'd0,  6'd0,  1'b1, ST_OK,           6'd0, 0, 7'd1));
		plan.push_back(step_row(OP_ACQUIRE, 6'd42, 6'd21, 1'b0, ST_OK,           6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_RELEASE, 6'd1,  6'd63, 1'b0, ST_OK,           6'd0, 0, 7'd0));
		plan.push_back(step_row(OP_RELEASE, 6'd0,  6'd42, 1'b0, ST_OK,           6'd0, 0, 7'd0));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			issue(plan[i].c, plan[i].typed, plan[i].r);
			maybe_idle(25);
		end
		drain_results();

		run_phase(60, 35, 25, 30);
		run_phase(100, 85, 5, 20);
		run_phase(100, 8, 85, 30);
		run_phase(80, 40, 35, 25);
		run_phase(90, 60, 25, 0);

		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && outcomes_due.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/gsa_pkg.sv
hw/rtl/gsa_ram.sv
hw/rtl/generational_slot_allocator.sv
hw/rtl/gsa_checker.sv
sim/tb_generational_slot_allocator.sv
